@@ rtl/caprt_pkg.sv @@
// ----------------------------------------------------------------------------
// caprt_pkg
// Shared types and constants for the camera align / rotate points block.
// ----------------------------------------------------------------------------
package caprt_pkg;

   // Coordinate width of points, camera position and view results (16..64).
   localparam int COORD_WIDTH = 32;
   localparam int DIR_WIDTH   = 32;
   localparam int MAT_WIDTH   = 32;
   localparam int FRAC        = 29;
   // Register write data: as wide as the widest register.
   localparam int CSR_WIDTH   = (COORD_WIDTH > DIR_WIDTH) ? COORD_WIDTH : DIR_WIDTH;

   localparam logic signed [31:0] Q_ONE    = 32'sd536870912;
   localparam logic signed [31:0] TILT_COS = 32'sd518577533;
   localparam logic signed [31:0] TILT_SIN = 32'sd138952216;

   // Register indexes.
   localparam logic [2:0] REG_CAM_POS_X = 3'd0;
   localparam logic [2:0] REG_CAM_POS_Y = 3'd1;
   localparam logic [2:0] REG_CAM_POS_Z = 3'd2;
   localparam logic [2:0] REG_CAM_DIR_X = 3'd3;
   localparam logic [2:0] REG_CAM_DIR_Y = 3'd4;
   localparam logic [2:0] REG_CAM_DIR_Z = 3'd5;
   localparam logic [2:0] REG_SKIP_TILT = 3'd6;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] view_x;
      logic signed [COORD_WIDTH-1:0] view_y;
      logic signed [COORD_WIDTH-1:0] view_z;
      logic                          at_camera;
   } rsp_type;

   // Row-major 3x3 rotation, Q2.29 entries.
   typedef logic [8:0][MAT_WIDTH-1:0] mat_type;

endpackage

@@ rtl/caprt_matrix.sv @@
// ----------------------------------------------------------------------------
// caprt_matrix
// Sequencer that builds the Q2.29 rotation from the camera direction with
// one shared multiplier, a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module caprt_matrix (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [31:0]       dir_x,
   input  logic signed [31:0]       dir_y,
   input  logic signed [31:0]       dir_z,
   input  logic                     skip,
   output caprt_pkg::mat_type       mat,
   output logic                     mat_ok
);

   localparam logic [3:0] S_START = 4'd0;
   localparam logic [3:0] S_NORM  = 4'd1;
   localparam logic [3:0] S_SQ    = 4'd2;
   localparam logic [3:0] S_RT1   = 4'd3;
   localparam logic [3:0] S_RT2   = 4'd4;
   localparam logic [3:0] S_DSET  = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   localparam logic [63:0] ROOT_BIT  = 64'h4000_0000_0000_0000;
   localparam logic [63:0] HALF64    = 64'd1 << (caprt_pkg::FRAC - 1);
   localparam logic [5:0]  DIV_LAST  = 6'd61;

   logic [3:0]         state_ff, state_in;
   logic [31:0]        ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [63:0] p_ff, p_in;
   logic [63:0]        ss_ff, ss_in, x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic [31:0]        len_ff, len_in, sl_ff, sl_in;
   logic [61:0]        num_ff, num_in, quo_ff, quo_in;
   logic [32:0]        rem_ff, rem_in;
   logic [31:0]        den_ff, den_in;
   logic [1:0]         dcnt_ff, dcnt_in;
   logic signed [31:0] c_ff, c_in, s_ff, s_in, kx_ff, kx_in, ky_ff, ky_in, t_ff, t_in;
   logic signed [31:0] pr0_ff, pr0_in, pr1_ff, pr1_in, pr2_ff, pr2_in;
   logic signed [31:0] m0_ff, m0_in, m1_ff, m1_in, m2_ff, m2_in, m4_ff, m4_in, m5_ff, m5_in;
   logic [2:0]         mop_ff, mop_in;
   logic               mph_ff, mph_in;
   caprt_pkg::mat_type mat_ff, mat_in;
   logic               ok_ff, ok_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [63:0]        rt_sum, rt_r;
   logic [32:0]        dv_tr;
   logic               dv_bit;
   logic [61:0]        dv_q;
   logic [31:0]        qv;
   logic               p_neg;
   logic [63:0]        p_mag, p_rnd;
   logic signed [31:0] rq;

   function automatic logic [31:0] clampq(input logic signed [31:0] v);
      if (v > caprt_pkg::Q_ONE) begin
         return caprt_pkg::Q_ONE;
      end else if (v < -caprt_pkg::Q_ONE) begin
         return -caprt_pkg::Q_ONE;
      end
      return v;
   endfunction

   function automatic logic [31:0] absv(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   assign mul_p  = mul_a * mul_b;
   assign rt_sum = r_ff + bit_ff;
   assign rt_r   = (x_ff >= rt_sum) ? ((r_ff >> 1) + bit_ff) : (r_ff >> 1);
   assign dv_tr  = {rem_ff[31:0], num_ff[61]};
   assign dv_bit = (dv_tr >= {1'b0, den_ff});
   assign dv_q   = {quo_ff[60:0], dv_bit};
   assign qv     = {1'b0, dv_q[30:0]};
   // round to nearest, half away from zero
   assign p_neg  = p_ff[63];
   assign p_mag  = p_neg ? (~p_ff + 64'd1) : p_ff;
   assign p_rnd  = (p_mag + HALF64) >> caprt_pkg::FRAC;
   assign rq     = p_neg ? -$signed(p_rnd[31:0]) : $signed(p_rnd[31:0]);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            case (cnt_ff[1:0])
               2'd0:    begin mul_a = {1'b0, ax_ff}; mul_b = {1'b0, ax_ff}; end
               2'd1:    begin mul_a = {1'b0, ay_ff}; mul_b = {1'b0, ay_ff}; end
               default: begin mul_a = {1'b0, az_ff}; mul_b = {1'b0, az_ff}; end
            endcase
         end
         S_MUL: begin
            case (mop_ff)
               3'd0:    begin mul_a = 33'(kx_ff); mul_b = 33'(kx_ff); end
               3'd1:    begin mul_a = 33'(kx_ff); mul_b = 33'(ky_ff); end
               3'd2:    begin mul_a = 33'(ky_ff); mul_b = 33'(ky_ff); end
               3'd3:    begin mul_a = 33'(ky_ff); mul_b = 33'(s_ff);  end
               3'd4:    begin mul_a = 33'(kx_ff); mul_b = 33'(s_ff);  end
               3'd5:    begin mul_a = 33'(t_ff);  mul_b = 33'(pr0_ff); end
               3'd6:    begin mul_a = 33'(t_ff);  mul_b = 33'(pr1_ff); end
               default: begin mul_a = 33'(t_ff);  mul_b = 33'(pr2_ff); end
            endcase
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      cnt_in = cnt_ff; p_in = p_ff; ss_in = ss_ff;
      x_in = x_ff; r_in = r_ff; bit_in = bit_ff;
      len_in = len_ff; sl_in = sl_ff;
      num_in = num_ff; quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      dcnt_in = dcnt_ff;
      c_in = c_ff; s_in = s_ff; kx_in = kx_ff; ky_in = ky_ff; t_in = t_ff;
      pr0_in = pr0_ff; pr1_in = pr1_ff; pr2_in = pr2_ff;
      m0_in = m0_ff; m1_in = m1_ff; m2_in = m2_ff; m4_in = m4_ff; m5_in = m5_ff;
      mop_in = mop_ff; mph_in = mph_ff;
      mat_in = mat_ff; ok_in = ok_ff;
      case (state_ff)
         S_START: begin
            if (dir_x == 32'sd0 && dir_y == 32'sd0) begin
               // axis degenerates: plain rotation about z
               mat_in = '0;
               mat_in[0] = caprt_pkg::Q_ONE;
               mat_in[4] = caprt_pkg::Q_ONE;
               mat_in[8] = caprt_pkg::Q_ONE;
               if (dir_z > 32'sd0) begin
                  mat_in[0] = -caprt_pkg::Q_ONE;
                  mat_in[4] = -caprt_pkg::Q_ONE;
               end else if (!skip) begin
                  mat_in[0] = caprt_pkg::TILT_COS;
                  mat_in[1] = -caprt_pkg::TILT_SIN;
                  mat_in[3] = caprt_pkg::TILT_SIN;
                  mat_in[4] = caprt_pkg::TILT_COS;
               end
               ok_in    = 1'b1;
               state_in = S_DONE;
            end else begin
               ax_in = absv(dir_x);
               ay_in = absv(dir_y);
               az_in = absv(dir_z);
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if ((ax_ff[31:30] | ay_ff[31:30] | az_ff[31:30]) != 2'b00) begin
               cnt_in   = '0;
               state_in = S_SQ;
            end else begin
               ax_in = ax_ff << 1;
               ay_in = ay_ff << 1;
               az_in = az_ff << 1;
            end
         end
         S_SQ: begin
            cnt_in = cnt_ff + 6'd1;
            p_in   = mul_p[63:0];
            case (cnt_ff[1:0])
               2'd0:    ss_in = ss_ff;
               2'd1:    ss_in = p_ff;
               2'd2:    ss_in = ss_ff + p_ff;
               default: begin
                  x_in     = ss_ff + p_ff;
                  r_in     = '0;
                  bit_in   = ROOT_BIT;
                  state_in = S_RT1;
               end
            endcase
         end
         S_RT1, S_RT2: begin
            if (x_ff >= rt_sum) begin
               x_in = x_ff - rt_sum;
            end
            r_in   = rt_r;
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               if (state_ff == S_RT1) begin
                  len_in   = rt_r[31:0];
                  x_in     = ss_ff;
                  r_in     = '0;
                  bit_in   = ROOT_BIT;
                  state_in = S_RT2;
               end else begin
                  sl_in    = rt_r[31:0];
                  dcnt_in  = '0;
                  state_in = S_DSET;
               end
            end
         end
         S_DSET: begin
            case (dcnt_ff)
               2'd0:    begin num_in = {1'b0, az_ff, 29'd0} + 62'(len_ff >> 1); den_in = len_ff; end
               2'd1:    begin num_in = {1'b0, sl_ff, 29'd0} + 62'(len_ff >> 1); den_in = len_ff; end
               2'd2:    begin num_in = {1'b0, ay_ff, 29'd0} + 62'(sl_ff >> 1);  den_in = sl_ff;  end
               default: begin num_in = {1'b0, ax_ff, 29'd0} + 62'(sl_ff >> 1);  den_in = sl_ff;  end
            endcase
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = dv_bit ? (dv_tr - {1'b0, den_ff}) : dv_tr;
            quo_in = dv_q;
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               case (dcnt_ff)
                  2'd0: begin
                     c_in = (dir_z > 32'sd0) ? -$signed(qv) : $signed(qv);
                     t_in = caprt_pkg::Q_ONE - ((dir_z > 32'sd0) ? -$signed(qv) : $signed(qv));
                  end
                  2'd1:    s_in  = -$signed(qv);
                  2'd2:    kx_in = (dir_y > 32'sd0) ? -$signed(qv) : $signed(qv);
                  default: ky_in = (dir_x < 32'sd0) ? -$signed(qv) : $signed(qv);
               endcase
               if (dcnt_ff == 2'd3) begin
                  mop_in   = '0;
                  mph_in   = 1'b0;
                  state_in = S_MUL;
               end else begin
                  dcnt_in  = dcnt_ff + 2'd1;
                  state_in = S_DSET;
               end
            end
         end
         S_MUL: begin
            mph_in = ~mph_ff;
            if (!mph_ff) begin
               p_in = mul_p[63:0];
            end else begin
               mop_in = mop_ff + 3'd1;
               case (mop_ff)
                  3'd0:    pr0_in = rq;
                  3'd1:    pr1_in = rq;
                  3'd2:    pr2_in = rq;
                  3'd3:    m2_in  = rq;
                  3'd4:    m5_in  = -rq;
                  3'd5:    m0_in  = c_ff + rq;
                  3'd6:    m1_in  = rq;
                  default: begin
                     m4_in    = c_ff + rq;
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_FIN: begin
            mat_in[0] = clampq(m0_ff);
            mat_in[1] = clampq(m1_ff);
            mat_in[2] = clampq(m2_ff);
            mat_in[3] = clampq(m1_ff);
            mat_in[4] = clampq(m4_ff);
            mat_in[5] = clampq(m5_ff);
            mat_in[6] = clampq(-m2_ff);
            mat_in[7] = clampq(-m5_ff);
            mat_in[8] = clampq(c_ff);
            ok_in     = 1'b1;
            state_in  = S_DONE;
         end
         default: begin
            state_in = S_DONE;
         end
      endcase
      if (start) begin
         ok_in    = 1'b0;
         state_in = S_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_START;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
      end
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
      cnt_ff <= cnt_in; p_ff <= p_in; ss_ff <= ss_in;
      x_ff <= x_in; r_ff <= r_in; bit_ff <= bit_in;
      len_ff <= len_in; sl_ff <= sl_in;
      num_ff <= num_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
      dcnt_ff <= dcnt_in;
      c_ff <= c_in; s_ff <= s_in; kx_ff <= kx_in; ky_ff <= ky_in; t_ff <= t_in;
      pr0_ff <= pr0_in; pr1_ff <= pr1_in; pr2_ff <= pr2_in;
      m0_ff <= m0_in; m1_ff <= m1_in; m2_ff <= m2_in; m4_ff <= m4_in; m5_ff <= m5_in;
      mop_ff <= mop_in; mph_ff <= mph_in;
      mat_ff <= mat_in;
   end

   assign mat    = mat_ff;
   assign mat_ok = ok_ff;

endmodule

@@ rtl/caprt_pipe.sv @@
// ----------------------------------------------------------------------------
// caprt_pipe
// Four-stage point datapath: offset, products, row sums, round/saturate.
// ----------------------------------------------------------------------------
module caprt_pipe (
   input  logic                                clock,
   input  logic                                reset,
   input  caprt_pkg::mat_type                  mat,
   input  logic                                mat_ok,
   input  logic [caprt_pkg::COORD_WIDTH-1:0]   pos_x,
   input  logic [caprt_pkg::COORD_WIDTH-1:0]   pos_y,
   input  logic [caprt_pkg::COORD_WIDTH-1:0]   pos_z,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  caprt_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output caprt_pkg::rsp_type                  rsp_data
);

   localparam int CW   = caprt_pkg::COORD_WIDTH;
   localparam int DROP = (CW > 32) ? CW - 32 : 0;
   localparam int SW   = CW - DROP;
   localparam int DW   = SW + 1;
   localparam int PW   = caprt_pkg::MAT_WIDTH + DW;
   localparam int AW   = PW + 2;
   localparam logic signed [AW-1:0] LIM  = (AW'(1) <<< (SW - 1)) - AW'(1);
   localparam logic signed [AW-1:0] NLIM = -LIM - AW'(1);
   localparam logic [AW-1:0]        HALF = AW'(1) << (caprt_pkg::FRAC - 1);
   localparam logic [CW-1:0]        MAXV = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0]        MINV = {1'b1, {(CW-1){1'b0}}};

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4, take;
   logic signed [DW-1:0] d_in [3], d_ff [3];
   logic at1_ff, at2_ff, at3_ff;
   logic signed [PW-1:0] prod_ff [9];
   logic signed [AW-1:0] acc_in [3], acc_ff [3];
   logic [CW-1:0]        pin [3], qin [3];
   logic [CW-1:0]        view_in [3];
   caprt_pkg::rsp_type   rsp_ff, rsp_in;

   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall = !rdy1 || !mat_ok;
   assign take = req_valid && !req_stall;

   assign pin[0] = req_data.point_x;
   assign pin[1] = req_data.point_y;
   assign pin[2] = req_data.point_z;
   assign qin[0] = pos_x;
   assign qin[1] = pos_y;
   assign qin[2] = pos_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [SW-1:0] ps, qs;
         ps = pin[i][CW-1:DROP];
         qs = qin[i][CW-1:DROP];
         d_in[i] = $signed({ps[SW-1], ps}) - $signed({qs[SW-1], qs});
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = AW'(prod_ff[3*i]) + AW'(prod_ff[3*i+1]) + AW'(prod_ff[3*i+2]);
      end
   end

   // round half away from zero, then saturate and scale back
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic          neg;
         logic [AW-1:0] mag, rq;
         logic signed [AW-1:0] r;
         neg = acc_ff[i][AW-1];
         mag = neg ? -acc_ff[i] : acc_ff[i];
         rq  = (mag + HALF) >> caprt_pkg::FRAC;
         r   = neg ? -$signed(rq) : $signed(rq);
         if (r > LIM) begin
            view_in[i] = MAXV;
         end else if (r < NLIM) begin
            view_in[i] = MINV;
         end else begin
            view_in[i] = CW'(r[SW-1:0]) << DROP;
         end
      end
   end

   always_comb begin
      rsp_in           = rsp_ff;
      rsp_in.view_x    = at3_ff ? '0 : view_in[0];
      rsp_in.view_y    = at3_ff ? '0 : view_in[1];
      rsp_in.view_z    = at3_ff ? '0 : view_in[2];
      rsp_in.at_camera = at3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= take;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
      if (rdy1 && take) begin
         d_ff   <= d_in;
         at1_ff <= (pin[0] == qin[0]) && (pin[1] == qin[1]) && (pin[2] == qin[2]);
      end
      if (rdy2 && v1_ff) begin
         for (int k = 0; k < 9; k++) begin
            prod_ff[k] <= $signed(mat[k]) * d_ff[k % 3];
         end
         at2_ff <= at1_ff;
      end
      if (rdy3 && v2_ff) begin
         acc_ff <= acc_in;
         at3_ff <= at2_ff;
      end
      if (rdy4 && v3_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/camera_align_rotate_points_top.sv @@
// A point beat accepted at a clock edge comes out as a result beat after four
// register stages, the first loaded at the accepting edge. Throughput: one point
// per cycle, set by the four-stage multiply/sum pipeline, while mat_ok is high and
// rsp_stall does not back the pipeline up. After reset and any register write a
// sequencer (bit-serial root and divider) rebuilds the rotation, req_stall held.
// Reset is synchronous, active high: camera at the origin looking down -z, tilt on.
// ----------------------------------------------------------------------------
// camera_align_rotate_points_top
// View transform of scene points: subtract camera position, rotate so the
// camera direction lands on -z, round and saturate in Q16.16.
// ----------------------------------------------------------------------------
module camera_align_rotate_points_top (
   input  logic                                clock,
   input  logic                                reset,
   // point channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  caprt_pkg::req_type                  req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output caprt_pkg::rsp_type                  rsp_data,
   // register write port
   input  logic                                csr_write_en,
   input  logic [2:0]                          csr_index,
   input  logic [caprt_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   localparam int CW  = caprt_pkg::COORD_WIDTH;

   // camera registers
   logic [CW-1:0]        pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [31:0]   dir_x_ff, dir_y_ff, dir_z_ff;
   logic                 skip_ff;

   caprt_pkg::mat_type   mat;
   logic                 mat_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         dir_x_ff <= '0;
         dir_y_ff <= '0;
         dir_z_ff <= -32'sd65536;
         skip_ff  <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            caprt_pkg::REG_CAM_POS_X: pos_x_ff <= csr_wdata[CW-1:0];
            caprt_pkg::REG_CAM_POS_Y: pos_y_ff <= csr_wdata[CW-1:0];
            caprt_pkg::REG_CAM_POS_Z: pos_z_ff <= csr_wdata[CW-1:0];
            caprt_pkg::REG_CAM_DIR_X: dir_x_ff <= csr_wdata[31:0];
            caprt_pkg::REG_CAM_DIR_Y: dir_y_ff <= csr_wdata[31:0];
            caprt_pkg::REG_CAM_DIR_Z: dir_z_ff <= csr_wdata[31:0];
            caprt_pkg::REG_SKIP_TILT: skip_ff  <= csr_wdata[0];
            default: begin
               skip_ff <= skip_ff;   // out-of-range index: no register
            end
         endcase
      end
   end

   // Rotation builder; any write restarts it, the datapath waits on mat_ok.
   caprt_matrix u_matrix (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_write_en),
      .dir_x  (dir_x_ff),
      .dir_y  (dir_y_ff),
      .dir_z  (dir_z_ff),
      .skip   (skip_ff),
      .mat    (mat),
      .mat_ok (mat_ok)
   );

   // Point pipeline: valid bits ride with each stage, stall backs up cleanly.
   caprt_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .mat       (mat),
      .mat_ok    (mat_ok),
      .pos_x     (pos_x_ff),
      .pos_y     (pos_y_ff),
      .pos_z     (pos_z_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
